[src/iidl_pkg.sv]
// Shared constants and types for the indexed insert/delete list.
// Used by the channel interfaces, the storage cell and the top level.
`default_nettype none
package iidl_pkg;

	localparam int KIND_W   = 3;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic app_en;
		logic ins_en;
		logic del_en;
	} iidl_ctrl_t;

endpackage
`default_nettype wire

[src/iidl_req_if.sv]
// Request channel of the indexed insert/delete list: valid, ready and operation.
// Depends on iidl_pkg.
`default_nettype none
interface iidl_req_if
	import iidl_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value_in;

	modport source (output valid, output kind, output position, output value_in, input ready);
	modport sink (input valid, input kind, input position, input value_in, output ready);
endinterface
`default_nettype wire

[src/iidl_rsp_if.sv]
// Result channel of the indexed insert/delete list: valid, ready and result fields.
// Depends on iidl_pkg.
`default_nettype none
interface iidl_rsp_if
	import iidl_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [POS_W-1:0]         placed_at;
	logic signed [DATA_W-1:0] value_out;
	logic [COUNT_W-1:0]       entry_count;

	modport source (output valid, output status, output placed_at, output value_out,
		output entry_count, input ready);
	modport sink (input valid, input status, input placed_at, input value_out,
		input entry_count, output ready);
endinterface
`default_nettype wire

[src/iidl_cell.sv]
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on iidl_pkg for the shift control struct.
`default_nettype none
module iidl_cell
	import iidl_pkg::*;
	#(
	parameter int IDX   = 0,
	parameter int CMP_W = 9
) (
	input  wire logic                     clk,
	input  wire iidl_ctrl_t               ctrl,
	input  wire logic [CMP_W-1:0]         pos,
	input  wire logic [CMP_W-1:0]         cnt,
	input  wire logic signed [DATA_W-1:0] value_in,
	input  wire logic signed [DATA_W-1:0] left,
	input  wire logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0]      value
);

	localparam logic [CMP_W-1:0] MY_IDX   = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] NEXT_IDX = CMP_W'(IDX + 1);

	logic signed [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.app_en && (cnt == MY_IDX)) begin
			entry_q <= value_in;
		end else if (ctrl.ins_en && (pos == MY_IDX)) begin
			entry_q <= value_in;
		end else if (ctrl.ins_en && (MY_IDX > pos) && (MY_IDX <= cnt)) begin
			entry_q <= left;
		end else if (ctrl.del_en && (MY_IDX >= pos) && (NEXT_IDX < cnt)) begin
			entry_q <= right;
		end
	end

	assign value = entry_q;

endmodule
`default_nettype wire

[src/indexed_insert_delete_list.sv]
// Top level of the indexed insert/delete list: control, cell row and result register.
// Depends on iidl_pkg, iidl_req_if, iidl_rsp_if and iidl_cell.
//
// An ordered list of up to DEPTH signed 32-bit entries held in a row of cells, one
// entry per cell. Every request (append, insert, delete, read, clear) is done by one
// registered update: all cells shift toward or away from the addressed index at the
// same edge, and the one result is registered, so it appears in the cycle after the
// request is taken. A new request is taken in every cycle in which the result
// register is empty or being emptied, giving one request per cycle sustained. The
// longest path is the read selection across all DEPTH cells. An append or insert on a
// full list is dropped with status full; the list comes out of reset empty.
`default_nettype none
module indexed_insert_delete_list
	import iidl_pkg::*;
	#(
	parameter int DEPTH = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iidl_req_if.sink   req,
	iidl_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;
	localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);
	localparam logic [CMP_W-1:0] CNT_ONE  = CMP_W'(1);

	logic [CMP_W-1:0]         cnt_q;
	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [POS_W-1:0]         placed_q;
	logic signed [DATA_W-1:0] value_q;
	logic [CMP_W-1:0]         cnt_next;
	logic [STATUS_W-1:0]      status_d;
	logic [POS_W-1:0]         placed_d;
	logic signed [DATA_W-1:0] value_d;
	logic [CMP_W-1:0]         pos_ext;
	logic                     accept;
	logic                     full;
	logic                     in_range;
	iidl_ctrl_t               ctrl_d;
	iidl_ctrl_t               ctrl;

	logic signed [DATA_W-1:0] cell_val [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_ext   = CMP_W'(req.position);
	assign full      = (cnt_q >= FULL_CNT);
	assign in_range  = (pos_ext < cnt_q);

	always_comb begin
		ctrl_d   = '0;
		cnt_next = cnt_q;
		status_d = ST_DONE;
		placed_d = '0;
		value_d  = '0;
		case (req.kind)
			KIND_APPEND, KIND_INSERT: begin
				if ((req.kind == KIND_INSERT) && in_range) begin
					placed_d = req.position;
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctrl_d.ins_en = 1'b1;
						cnt_next      = cnt_q + CNT_ONE;
					end
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl_d.app_en = 1'b1;
					placed_d      = cnt_q[POS_W-1:0];
					cnt_next      = cnt_q + CNT_ONE;
				end
			end
			KIND_DELETE: begin
				placed_d = req.position;
				if (in_range) begin
					ctrl_d.del_en = 1'b1;
					cnt_next      = cnt_q - CNT_ONE;
				end else begin
					status_d = ST_RANGE;
				end
			end
			KIND_READ: begin
				placed_d = req.position;
				if (in_range) begin
					value_d = cell_val[pos_ext[IDX_W-1:0]];
				end else begin
					status_d = ST_RANGE;
				end
			end
			KIND_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				cnt_next = cnt_q;
			end
		endcase
	end

	assign ctrl = accept ? ctrl_d : '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_val;
		logic signed [DATA_W-1:0] right_val;

		if (g == 0) begin : g_first
			assign left_val = req.value_in;
		end else begin : g_mid_left
			assign left_val = cell_val[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_right
			assign right_val = cell_val[g+1];
		end

		iidl_cell #(
			.IDX   (g),
			.CMP_W (CMP_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.pos      (pos_ext),
			.cnt      (cnt_q),
			.value_in (req.value_in),
			.left     (left_val),
			.right    (right_val),
			.value    (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			placed_q <= placed_d;
			value_q  <= value_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.placed_at   = placed_q;
	assign rsp.value_out   = value_q;
	assign rsp.entry_count = cnt_q[COUNT_W-1:0];

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count exceeds the list depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("taken request produced no result");

	a_full_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full |=> cnt_q <= $past(cnt_q))
		else $error("full list grew");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != ST_DONE) |-> rsp.value_out == '0)
		else $error("failed request returned nonzero data");
`endif

endmodule
`default_nettype wire
